// ===== design/bfd_pkg.sv =====
// Shared types and constants for the box filter downsampler.
// No dependencies; imported by every module of the block.
package bfd_pkg;

    localparam int PIX_W   = 8;   // canvas and output pixel width
    localparam int POS_W   = 11;  // column / row position width
    localparam int SIZE_W  = 12;  // canvas size register width
    localparam int HSUM_W  = 11;  // horizontal sum over up to 8 pixels
    localparam int SUM_W   = 14;  // block sum over up to 8 by 8 pixels
    localparam int FL_W    = 2;   // factor_log2 register width
    localparam int SHIFT_W = 3;   // 2 * factor_log2
    localparam int CIDX_W  = 2;   // config register index width

    localparam logic [SIZE_W-1:0] CANVAS_LIMIT = 12'd2048;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] REG_FACTOR_LOG2   = 2'd0;
    localparam logic [CIDX_W-1:0] REG_CANVAS_WIDTH  = 2'd1;
    localparam logic [CIDX_W-1:0] REG_CANVAS_HEIGHT = 2'd2;

    // Per-pixel control decoded from the raster position
    typedef struct packed {
        logic                do_sum;    // last pixel of a block row, inside the cropped area
        logic                first_row; // first row of the block: no stored partial sum
        logic                emit;      // last row of the block: give a result
        logic                row_end;
        logic                frame_end;
        logic [SHIFT_W-1:0]  shift;
        logic [HSUM_W-1:0]   hsum;
    } item_ctl_t;

endpackage

// ===== design/box_filter_downsampler_unit.sv =====
// Box filter downsampler: averages k-by-k blocks of a raster pixel stream, k = 2^factor_log2.
// Path: a block's result goes through the stage 1 register and then the output register.
// Throughput: one pixel per cycle sustained while the output is not stalled; the row store has one read and one write
// port, and the same column entry is touched again only a full canvas row later.
// Reset: aresetn synchronous, active low; clears factor to 0, size to 1 by 1 and the
// raster position. The row store is not cleared: a block's first row writes it first.
module box_filter_downsampler_unit
    import bfd_pkg::*;
#(
    parameter int MAX_OUT_WIDTH   = 1024,
    parameter int MAX_FACTOR_LOG2 = 3
) (
    input  logic              aclk,
    input  logic              aresetn,
    // configuration write channel
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0] cfg_data,
    // canvas pixel stream
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] pixel_in
    // downsampled pixel stream
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [7:0]        m_tdata,   // [7:0] pixel_out
    output logic              m_tlast,   // row_end
    output logic [0:0]        m_tuser    // [0] frame_end
);

    localparam int AW = $clog2(MAX_OUT_WIDTH);

    // Stage 0: position decode and row store read
    item_ctl_t        s0_ctl;
    logic [AW-1:0]    s0_addr;
    logic             s_accept;

    // Stage 1: block sum, row store write or result
    logic             s1_valid_reg, s1_valid_next;
    item_ctl_t        s1_ctl_reg;
    logic [AW-1:0]    s1_addr_reg;
    logic             s1_go;
    logic [SUM_W-1:0] s1_rd_data, s1_total;

    // Output register
    logic             out_valid_reg, out_valid_next;
    logic [PIX_W-1:0] out_pix_reg;
    logic             out_row_end_reg, out_frame_end_reg;

    logic             rd_en, wr_en;

    // Registers are writable out of reset; the user keeps the block idle when written, which it does not enforce.
    assign cfg_ready = aresetn;

    // Advance stage 1 unless it holds a result and the output register is full and not being taken.
    assign s1_go    = s1_valid_reg && (!s1_ctl_reg.emit || !out_valid_reg || m_tready);
    assign s_tready = aresetn && (!s1_valid_reg || s1_go);
    assign s_accept = s_tvalid && s_tready;

    bfd_pos_ctrl #(
        .MAX_OUT_WIDTH  (MAX_OUT_WIDTH),
        .MAX_FACTOR_LOG2(MAX_FACTOR_LOG2),
        .AW             (AW)
    ) u_pos_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_accept(s_accept),
        .pix       (s_tdata),
        .ctl       (s0_ctl),
        .col_addr  (s0_addr)
    );

    // Read the stored partial sum for any block row past the first.
    assign rd_en = s_accept && s0_ctl.do_sum && !s0_ctl.first_row;
    // Write the partial sum back on every block row but the last.
    assign wr_en = s1_go && !s1_ctl_reg.emit;

    bfd_row_store #(
        .DEPTH(MAX_OUT_WIDTH),
        .AW   (AW)
    ) u_row_store (
        .aclk   (aclk),
        .wr_en  (wr_en),
        .wr_addr(s1_addr_reg),
        .wr_data(s1_total),
        .rd_en  (rd_en),
        .rd_addr(s0_addr),
        .rd_data(s1_rd_data)
    );

    // Block sum: this row's horizontal sum plus the rows above it.
    assign s1_total = SUM_W'(s1_ctl_reg.hsum) +
                      (s1_ctl_reg.first_row ? '0 : s1_rd_data);

    always_comb begin
        s1_valid_next = s1_valid_reg;
        if (s1_go) begin
            s1_valid_next = 1'b0;
        end
        // only pixels that close a block row need stage 1
        if (s_accept) begin
            s1_valid_next = s0_ctl.do_sum;
        end

        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (s1_go && s1_ctl_reg.emit) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: load on advance, hold otherwise.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            s1_ctl_reg  <= s0_ctl;
            s1_addr_reg <= s0_addr;
        end
        if (s1_go && s1_ctl_reg.emit) begin
            out_pix_reg       <= PIX_W'(s1_total >> s1_ctl_reg.shift);
            out_row_end_reg   <= s1_ctl_reg.row_end;
            out_frame_end_reg <= s1_ctl_reg.frame_end;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_pix_reg;
    assign m_tlast    = out_row_end_reg;
    assign m_tuser[0] = out_frame_end_reg;

    // The same column entry is never read and written in one cycle.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(rd_en && wr_en && (s0_addr == s1_addr_reg)))
        else $error("row store read and write collide on one column");

    // Last pixel of the image is always the last pixel of its row.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser[0] |-> m_tlast)
        else $error("frame end without row end");

    // Read data must stay put while stage 1 waits on the output.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !s1_go |=> $stable(s1_rd_data))
        else $error("row store read word lost during stall");

    // A taken result with nothing behind it leaves the output empty.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !(s1_go && s1_ctl_reg.emit) |=> !m_tvalid)
        else $error("result repeated on the output");

endmodule

// ===== design/bfd_pos_ctrl.sv =====
// Raster position tracking, configuration registers and horizontal sum.
// Depends on bfd_pkg; decodes each accepted pixel into an item_ctl_t.
module bfd_pos_ctrl
    import bfd_pkg::*;
#(
    parameter int MAX_OUT_WIDTH   = 1024,
    parameter int MAX_FACTOR_LOG2 = 3,
    parameter int AW              = 10
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    input  logic [CIDX_W-1:0] cfg_index,
    input  logic [SIZE_W-1:0] cfg_data,
    input  logic              pix_accept,
    input  logic [PIX_W-1:0]  pix,
    output item_ctl_t         ctl,
    output logic [AW-1:0]     col_addr
);

    localparam logic [FL_W-1:0] FMAX =
        (MAX_FACTOR_LOG2 > 3) ? 2'd3 : FL_W'(MAX_FACTOR_LOG2);
    localparam logic [12:0] OW_MAX = 13'(MAX_OUT_WIDTH);

    logic [FL_W-1:0]   factor_reg;
    logic [SIZE_W-1:0] width_reg, height_reg;
    logic [POS_W-1:0]  col_reg, col_next;
    logic [POS_W-1:0]  row_reg, row_next;
    logic [HSUM_W-1:0] hsum_reg, hsum_next;

    logic [FL_W-1:0]   f;
    logic [SIZE_W-1:0] w, h;
    logic [12:0]       ow_full, ow, oh, col_lim, row_lim, oc, orow;
    logic [2:0]        kmask, cin, rin;
    logic              in_range, cfg_hit;

    assign cfg_hit = cfg_valid && (cfg_index == REG_FACTOR_LOG2 ||
                                   cfg_index == REG_CANVAS_WIDTH ||
                                   cfg_index == REG_CANVAS_HEIGHT);

    always_comb begin
        f = (factor_reg > FMAX) ? FMAX : factor_reg;
        w = (width_reg == '0) ? SIZE_W'(1) :
            (width_reg > CANVAS_LIMIT) ? CANVAS_LIMIT : width_reg;
        h = (height_reg == '0) ? SIZE_W'(1) :
            (height_reg > CANVAS_LIMIT) ? CANVAS_LIMIT : height_reg;
        ow_full = {1'b0, w >> f};
        ow      = (ow_full > OW_MAX) ? OW_MAX : ow_full;
        oh      = {1'b0, h >> f};
        col_lim = ow << f;
        row_lim = oh << f;
        kmask   = 3'((4'd1 << f) - 4'd1);
        cin     = col_reg[2:0] & kmask;
        rin     = row_reg[2:0] & kmask;
        oc      = {2'b0, col_reg} >> f;
        orow    = {2'b0, row_reg} >> f;
        in_range = ({2'b0, col_reg} < col_lim) && ({2'b0, row_reg} < row_lim);

        hsum_next = (cin == '0) ? HSUM_W'(pix) : hsum_reg + HSUM_W'(pix);

        ctl.do_sum    = in_range && (cin == kmask);
        ctl.first_row = (rin == '0);
        ctl.emit      = (rin == kmask);
        ctl.row_end   = (oc == ow - 13'd1);
        ctl.frame_end = (oc == ow - 13'd1) && (orow == oh - 13'd1);
        ctl.shift     = {f, 1'b0};
        ctl.hsum      = hsum_next;
        col_addr      = oc[AW-1:0];

        // advance the raster position, wrapping at row and frame ends
        col_next = col_reg + POS_W'(1);
        row_next = row_reg;
        if ({1'b0, col_reg} + SIZE_W'(1) >= w) begin
            col_next = '0;
            if ({1'b0, row_reg} + SIZE_W'(1) >= h) begin
                row_next = '0;
            end else begin
                row_next = row_reg + POS_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            factor_reg <= '0;
            width_reg  <= SIZE_W'(1);
            height_reg <= SIZE_W'(1);
            col_reg    <= '0;
            row_reg    <= '0;
            hsum_reg   <= '0;
        end else if (cfg_hit) begin
            case (cfg_index)
                REG_FACTOR_LOG2:   factor_reg <= cfg_data[FL_W-1:0];
                REG_CANVAS_WIDTH:  width_reg  <= cfg_data;
                REG_CANVAS_HEIGHT: height_reg <= cfg_data;
                default:           factor_reg <= factor_reg;
            endcase
            // restart the frame
            col_reg  <= '0;
            row_reg  <= '0;
            hsum_reg <= '0;
        end else if (pix_accept) begin
            col_reg <= col_next;
            row_reg <= row_next;
            if (in_range) begin
                hsum_reg <= hsum_next;
            end
        end
    end

endmodule

// ===== design/bfd_row_store.sv =====
// Row store of per-column partial block sums: one write and one read port.
// Depends on bfd_pkg; synchronous read with a registered output, no reset.
module bfd_row_store
    import bfd_pkg::*;
#(
    parameter int DEPTH = 1024,
    parameter int AW    = 10
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [SUM_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [SUM_W-1:0] rd_data
);

    logic [SUM_W-1:0] mem [DEPTH];
    logic [SUM_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // hold the read word until the next read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
